[src/psr_pkg.sv]
package psr_pkg;

	localparam int ACC_W           = 48;
	localparam int SAMPLE_W        = 32;
	localparam int WEIGHT_W        = 16;
	localparam int STEP_W          = 31;
	localparam int INDEX_W         = 8;
	localparam int DIVISOR_W       = 9;
	localparam int MAX_SAMPLES_DEF = 256;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register indexes, byte address = 4 * index
	localparam logic [2:0] REG_MODE         = 3'd0;
	localparam logic [2:0] REG_WINDOW_LOW   = 3'd1;
	localparam logic [2:0] REG_WINDOW_HIGH  = 3'd2;
	localparam logic [2:0] REG_STEP_LENGTH  = 3'd3;
	localparam logic [2:0] REG_FIRST_WEIGHT = 3'd4;
	localparam logic [2:0] REG_WEIGHT_RATIO = 3'd5;

	// reduction modes
	localparam logic [2:0] MODE_AVG   = 3'd0;
	localparam logic [2:0] MODE_RANGE = 3'd1;
	localparam logic [2:0] MODE_MAX   = 3'd2;
	localparam logic [2:0] MODE_MIN   = 3'd3;
	localparam logic [2:0] MODE_EXP   = 3'd4;
	localparam logic [2:0] MODE_SUM   = 3'd5;

	localparam logic [2:0]        MODE_RST        = MODE_MAX;
	localparam logic [STEP_W-1:0] STEP_LENGTH_RST = 31'd65536;

endpackage

[src/psr_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module psr_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [psr_pkg::ACC_W-1:0]      dividend,
	input  logic [psr_pkg::DIVISOR_W-1:0]  divisor,
	output logic                           done,
	output logic [psr_pkg::ACC_W-1:0]      quotient
);

	localparam int STEPS  = psr_pkg::ACC_W;
	localparam int STEP_W = $clog2(STEPS);
	localparam int DW     = psr_pkg::DIVISOR_W;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     divisor_q;
	logic [psr_pkg::ACC_W-1:0] quo_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[psr_pkg::ACC_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[psr_pkg::ACC_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/profile_sample_reducer_core.sv]
// channel  | handshake                 | payload
// in       | in_valid / in_stall       | sample[31:0] signed, last
// out      | out_valid / out_stall     | reduced[47:0] signed, extreme_index[7:0]
// config   | APB psel/penable/pready   | paddr[4:0], pwdata/prdata[31:0]
//
// A sample is accepted, then executed; exponential mode adds a weight step, the
// shared 33x17 multiplier forming the term and then the next weight.
// A last sample adds the finish and emit states, and average mode the divide state
// for the one-bit-per-cycle divider. in_stall is high whenever the sequencer is
// away from idle. The result sits in an output register, so a pending result blocks
// only the next last sample. Reset is asynchronous, active low; no clearing pass.
module profile_sample_reducer_core #(
	parameter int MAX_SAMPLES = psr_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [psr_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [psr_pkg::ACC_W-1:0]    reduced,
	output logic [psr_pkg::INDEX_W-1:0]         extreme_index,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [psr_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [psr_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [psr_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int AW    = psr_pkg::ACC_W;
	localparam int SW    = psr_pkg::SAMPLE_W;
	localparam int WW    = psr_pkg::WEIGHT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_STEP2  = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	// configuration
	logic [2:0]                 mode_q;
	logic signed [SW-1:0]       win_lo_q;
	logic signed [SW-1:0]       win_hi_q;
	logic [psr_pkg::STEP_W-1:0] step_len_q;
	logic [WW-1:0]              first_w_q;
	logic [WW-1:0]              ratio_q;

	// profile state
	logic [2:0]               state_q;
	logic [AW-1:0]            acc_q;
	logic signed [SW-1:0]     best_q;
	logic [psr_pkg::INDEX_W-1:0] best_pos_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [WW-1:0]            cur_w_q;
	logic                     inside_q;
	logic                     left_q;

	logic signed [SW-1:0]     sample_q;
	logic                     last_q;
	logic [WW-1:0]            w_q;
	logic signed [AW:0]       prod_q;
	logic                     neg_q;
	logic [AW-1:0]            res_q;
	logic [psr_pkg::INDEX_W-1:0] res_ix_q;

	logic                     out_valid_q;
	logic [AW-1:0]            out_res_q;
	logic [psr_pkg::INDEX_W-1:0] out_ix_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= psr_pkg::MODE_RST;
			win_lo_q   <= '0;
			win_hi_q   <= '0;
			step_len_q <= psr_pkg::STEP_LENGTH_RST;
			first_w_q  <= '0;
			ratio_q    <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				psr_pkg::REG_MODE:         mode_q     <= pwdata[2:0];
				psr_pkg::REG_WINDOW_LOW:   win_lo_q   <= pwdata;
				psr_pkg::REG_WINDOW_HIGH:  win_hi_q   <= pwdata;
				psr_pkg::REG_STEP_LENGTH:  step_len_q <= pwdata[psr_pkg::STEP_W-1:0];
				psr_pkg::REG_FIRST_WEIGHT: first_w_q  <= pwdata[WW-1:0];
				psr_pkg::REG_WEIGHT_RATIO: ratio_q    <= pwdata[WW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			psr_pkg::REG_MODE:         prdata = 32'(mode_q);
			psr_pkg::REG_WINDOW_LOW:   prdata = win_lo_q;
			psr_pkg::REG_WINDOW_HIGH:  prdata = win_hi_q;
			psr_pkg::REG_STEP_LENGTH:  prdata = 32'(step_len_q);
			psr_pkg::REG_FIRST_WEIGHT: prdata = 32'(first_w_q);
			psr_pkg::REG_WEIGHT_RATIO: prdata = 32'(ratio_q);
			default:                   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- datapath
	logic in_acc;
	logic out_free;
	logic counting;
	logic first_idx;
	logic in_win;
	logic [8:0] idx_ext;
	logic [WW-1:0] w_sel;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign counting  = cnt_q < CNT_W'(MAX_SAMPLES);
	assign first_idx = cnt_q == '0;
	assign in_win    = (sample_q >= win_lo_q) && (sample_q <= win_hi_q);
	assign idx_ext   = 9'(cnt_q);
	assign w_sel     = first_idx ? first_w_q : cur_w_q;

	// shared multiplier: sample x weight, then weight x ratio
	logic signed [SW:0]      mul_a;
	logic signed [WW:0]      mul_b;
	logic signed [SW+WW+1:0] mul_p;

	always_comb begin
		if (state_q == ST_STEP2) begin
			mul_a = (SW+1)'(w_q);
			mul_b = {1'b0, ratio_q};
		end else begin
			mul_a = {sample_q[SW-1], sample_q};
			mul_b = {1'b0, w_sel};
		end
	end
	assign mul_p = mul_a * mul_b;

	// exp term: floor((p + 32768) / 65536)
	logic signed [AW:0]  rnd;
	logic signed [AW:0]  term;
	logic [32:0]         w_rnd;
	assign rnd   = prod_q + (AW+1)'(32768);
	assign term  = rnd >>> 16;
	assign w_rnd = 33'(mul_p[31:0]) + 33'd32768;

	// shared accumulator adder
	logic [AW-1:0] addend;
	logic          acc_en;
	always_comb begin
		addend = '0;
		acc_en = 1'b0;
		if (state_q == ST_STEP2) begin
			addend = term[AW-1:0];
			acc_en = 1'b1;
		end else if (state_q == ST_EXEC && counting) begin
			case (mode_q)
				psr_pkg::MODE_AVG, psr_pkg::MODE_SUM: begin
					addend = AW'(sample_q);
					acc_en = 1'b1;
				end
				psr_pkg::MODE_RANGE: begin
					addend = AW'(step_len_q);
					acc_en = !left_q && !(inside_q && !in_win) && (inside_q || in_win);
				end
				default: ;
			endcase
		end
	end

	// average: magnitude division, sign restored after
	logic [AW-1:0] acc_mag;
	logic          div_start;
	logic          div_done;
	logic [AW-1:0] div_quo;
	assign acc_mag   = acc_q[AW-1] ? (~acc_q + 1'b1) : acc_q;
	assign div_start = state_q == ST_FINISH && mode_q == psr_pkg::MODE_AVG;

	psr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_mag),
		.divisor  (idx_ext),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			best_q      <= '0;
			best_pos_q  <= '0;
			cnt_q       <= '0;
			cur_w_q     <= '0;
			inside_q    <= 1'b0;
			left_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (acc_en)
				acc_q <= acc_q + addend;

			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (counting) begin
						case (mode_q)
							psr_pkg::MODE_RANGE: begin
								if (!left_q) begin
									if (inside_q && !in_win)
										left_q <= 1'b1;
									else if (in_win)
										inside_q <= 1'b1;
								end
							end
							psr_pkg::MODE_MAX: begin
								if (first_idx || sample_q > best_q) begin
									best_q     <= sample_q;
									best_pos_q <= idx_ext[7:0];
								end
							end
							psr_pkg::MODE_MIN: begin
								if (first_idx || sample_q < best_q) begin
									best_q     <= sample_q;
									best_pos_q <= idx_ext[7:0];
								end
							end
							default: ;
						endcase
						cnt_q <= cnt_q + 1'b1;
					end
					if (counting && mode_q == psr_pkg::MODE_EXP)
						state_q <= ST_STEP2;
					else if (last_q)
						state_q <= ST_FINISH;
					else
						state_q <= ST_IDLE;
				end
				ST_STEP2: begin
					cur_w_q <= w_rnd[31:16];
					state_q <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					state_q <= (mode_q == psr_pkg::MODE_AVG) ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						acc_q       <= '0;
						best_q      <= '0;
						best_pos_q  <= '0;
						cnt_q       <= '0;
						cur_w_q     <= '0;
						inside_q    <= 1'b0;
						left_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
			last_q   <= last;
		end
		if (state_q == ST_EXEC) begin
			w_q    <= w_sel;
			prod_q <= mul_p[AW:0];
		end
		if (state_q == ST_FINISH) begin
			neg_q <= acc_q[AW-1];
			case (mode_q)
				psr_pkg::MODE_RANGE, psr_pkg::MODE_EXP, psr_pkg::MODE_SUM: begin
					res_q    <= acc_q;
					res_ix_q <= '0;
				end
				psr_pkg::MODE_MAX, psr_pkg::MODE_MIN: begin
					res_q    <= AW'(best_q);
					res_ix_q <= best_pos_q;
				end
				default: begin
					res_q    <= '0;
					res_ix_q <= '0;
				end
			endcase
		end
		if (state_q == ST_DIV && div_done)
			res_q <= neg_q ? (~div_quo + 1'b1) : div_quo;
		if (state_q == ST_EMIT && out_free) begin
			out_res_q <= res_q;
			out_ix_q  <= res_ix_q;
		end
	end

	assign in_stall      = state_q != ST_IDLE;
	assign out_valid     = out_valid_q;
	assign reduced       = out_res_q;
	assign extreme_index = out_ix_q;

	// ---------------------------------------------------------------- checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond limit");

	a_left_implies_inside: assert property (@(posedge clk) disable iff (!arst_n)
		left_q |-> inside_q)
		else $error("window left without having been inside");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> (cnt_q == '0 && acc_q == '0 && out_valid_q))
		else $error("profile not cleared after result");

endmodule

[dv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SAMPLES    = psr_pkg::MAX_SAMPLES_DEF;
	localparam int SETTLE_CYCLES  = 64;   // covers last-sample overhead plus the divider
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PCT       = 18;
	localparam int RANDOM_ITEMS   = 1100;

	localparam int ACC_W    = psr_pkg::ACC_W;
	localparam int SAMPLE_W = psr_pkg::SAMPLE_W;
	localparam int INDEX_W  = psr_pkg::INDEX_W;
	localparam int STEP_W   = psr_pkg::STEP_W;
	localparam int WEIGHT_W = psr_pkg::WEIGHT_W;

	// mode encodings the block leaves undefined
	localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
	localparam logic [2:0] MODE_UNDEF_7 = 3'd7;

	typedef struct packed {
		logic [ACC_W-1:0]   reduced;
		logic [INDEX_W-1:0] ext_idx;
	} result_t;

	logic                               clk;
	logic                               arst_n        = 1'b0;
	logic                               in_valid      = 1'b0;
	logic                               in_stall;
	logic signed [SAMPLE_W-1:0]         sample        = '0;
	logic                               last          = 1'b0;
	logic                               out_valid;
	logic                               out_stall     = 1'b0;
	logic signed [ACC_W-1:0]            reduced;
	logic [INDEX_W-1:0]                 extreme_index;
	logic                               psel          = 1'b0;
	logic                               penable       = 1'b0;
	logic                               pwrite        = 1'b0;
	logic [psr_pkg::APB_ADDR_W-1:0]     paddr         = '0;
	logic [psr_pkg::APB_DATA_W-1:0]     pwdata        = '0;
	logic [psr_pkg::APB_DATA_W-1:0]     prdata;
	logic                               pready;

	// register shadow
	logic [2:0]                 cfg_mode   = psr_pkg::MODE_RST;
	logic signed [SAMPLE_W-1:0] cfg_win_lo = '0;
	logic signed [SAMPLE_W-1:0] cfg_win_hi = '0;
	logic [STEP_W-1:0]          cfg_step   = psr_pkg::STEP_LENGTH_RST;
	logic [WEIGHT_W-1:0]        cfg_w0     = '0;
	logic [WEIGHT_W-1:0]        cfg_ratio  = '0;

	// profile state mirror
	logic [ACC_W-1:0]              prof_acc      = '0;
	logic signed [SAMPLE_W-1:0]    prof_best     = '0;
	logic [INDEX_W-1:0]            prof_best_pos = '0;
	logic [psr_pkg::DIVISOR_W-1:0] prof_count    = '0;
	logic [WEIGHT_W-1:0]           prof_weight   = '0;
	logic                          prof_in_win   = 1'b0;
	logic                          prof_left     = 1'b0;

	result_t profile_results_due[$];
	int      mismatches   = 0;
	int      quiet_cycles = 0;
	bit      no_gaps      = 1'b0;

	profile_sample_reducer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reduced      (reduced),
		.extreme_index(extreme_index),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic clear_profile();
		prof_acc      = '0;
		prof_best     = '0;
		prof_best_pos = '0;
		prof_count    = '0;
		prof_weight   = '0;
		prof_in_win   = 1'b0;
		prof_left     = 1'b0;
	endtask

	// fold one accepted sample into the mirrored profile; queue the result on last
	task automatic fold_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
		logic [WEIGHT_W-1:0] w;
		logic [31:0]         w_next;
		longint              prod;
		logic                hit;
		result_t             r;
		if (prof_count < MAX_SAMPLES) begin
			case (cfg_mode)
				psr_pkg::MODE_AVG, psr_pkg::MODE_SUM: begin
					prof_acc = prof_acc + {{(ACC_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
				end
				psr_pkg::MODE_RANGE: begin
					hit = (s >= cfg_win_lo) && (s <= cfg_win_hi);
					if (!prof_left) begin
						if (prof_in_win && !hit) begin
							prof_left = 1'b1;
						end else begin
							if (hit)
								prof_in_win = 1'b1;
							if (prof_in_win)
								prof_acc = prof_acc + {{(ACC_W-STEP_W){1'b0}}, cfg_step};
						end
					end
				end
				psr_pkg::MODE_MAX: begin
					if (prof_count == 0 || s > prof_best) begin
						prof_best     = s;
						prof_best_pos = prof_count[INDEX_W-1:0];
					end
				end
				psr_pkg::MODE_MIN: begin
					if (prof_count == 0 || s < prof_best) begin
						prof_best     = s;
						prof_best_pos = prof_count[INDEX_W-1:0];
					end
				end
				psr_pkg::MODE_EXP: begin
					w           = (prof_count == 0) ? cfg_w0 : prof_weight;
					prod        = longint'(s) * longint'(w) + 64'sd32768;
					prof_acc    = prof_acc + ACC_W'(prod >>> 16);
					w_next      = w * cfg_ratio + 32'd32768;
					prof_weight = w_next[31:16];
				end
				default: ;
			endcase
			prof_count = prof_count + 1'b1;
		end
		if (l) begin
			r = '0;
			case (cfg_mode)
				psr_pkg::MODE_AVG:
					r.reduced = ACC_W'(longint'($signed(prof_acc)) / longint'(prof_count));
				psr_pkg::MODE_RANGE, psr_pkg::MODE_EXP, psr_pkg::MODE_SUM:
					r.reduced = prof_acc;
				psr_pkg::MODE_MAX, psr_pkg::MODE_MIN: begin
					r.reduced = {{(ACC_W-SAMPLE_W){prof_best[SAMPLE_W-1]}}, prof_best};
					r.ext_idx = prof_best_pos;
				end
				default: ;
			endcase
			profile_results_due.push_back(r);
			clear_profile();
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		last     <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		fold_sample(s, l);
	endtask

	// stop sending, wait for every queued result, then let the block go quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (profile_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			psr_pkg::REG_MODE:         cfg_mode   = value[2:0];
			psr_pkg::REG_WINDOW_LOW:   cfg_win_lo = value;
			psr_pkg::REG_WINDOW_HIGH:  cfg_win_hi = value;
			psr_pkg::REG_STEP_LENGTH:  cfg_step   = value[STEP_W-1:0];
			psr_pkg::REG_FIRST_WEIGHT: cfg_w0     = value[WEIGHT_W-1:0];
			psr_pkg::REG_WEIGHT_RATIO: cfg_ratio  = value[WEIGHT_W-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [31:0] r;
		int          d;
		r = $urandom;
		d = int'($urandom_range(0, 4)) - 2;
		case ($urandom_range(0, 5))
			0, 1: return r;
			2:    return {{14{r[17]}}, r[17:0]};
			3:    return cfg_win_lo + d;
			4:    return cfg_win_hi + d;
			default: begin
				case (r[1:0])
					2'd0: return 32'sh7FFFFFFF;
					2'd1: return 32'sh80000000;
					2'd2: return 32'sh00000000;
					default: return 32'shFFFFFFFF;
				endcase
			end
		endcase
	endfunction

	// reset mode is max: equal maxima keep the first index
	task automatic test_reset_mode();
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh7FFFFFFF, 1'b0);
		send_sample(32'sh7FFFFFFF, 1'b1);
	endtask

	task automatic test_each_mode();
		logic [2:0] modes[8];
		modes = '{psr_pkg::MODE_AVG, psr_pkg::MODE_RANGE, psr_pkg::MODE_MAX,
			psr_pkg::MODE_MIN, psr_pkg::MODE_EXP, psr_pkg::MODE_SUM,
			MODE_UNDEF_6, MODE_UNDEF_7};
		drain();
		write_reg(psr_pkg::REG_WINDOW_LOW, 32'hFFFF0000);
		write_reg(psr_pkg::REG_WINDOW_HIGH, 32'h00010000);
		write_reg(psr_pkg::REG_STEP_LENGTH, 32'h00010000);
		write_reg(psr_pkg::REG_FIRST_WEIGHT, 32'h0000FFFF);
		write_reg(psr_pkg::REG_WEIGHT_RATIO, 32'h00008000);
		foreach (modes[i]) begin
			drain();
			write_reg(psr_pkg::REG_MODE, {29'd0, modes[i]});
			// in range mode the second sample leaves the window, the third is ignored
			send_sample(32'sh00000000, 1'b0);
			send_sample(32'sh7FFFFFFF, 1'b0);
			send_sample(32'sh80000000, 1'b1);
		end
	endtask

	task automatic test_window_corners();
		drain();
		write_reg(psr_pkg::REG_MODE, {29'd0, psr_pkg::MODE_RANGE});
		// inverted window
		write_reg(psr_pkg::REG_WINDOW_LOW, 32'h00010000);
		write_reg(psr_pkg::REG_WINDOW_HIGH, 32'hFFFF0000);
		send_sample(32'sh00000000, 1'b0);
		send_sample(32'sh00010000, 1'b1);
		drain();
		// full window, zero step
		write_reg(psr_pkg::REG_WINDOW_LOW, 32'h80000000);
		write_reg(psr_pkg::REG_WINDOW_HIGH, 32'h7FFFFFFF);
		write_reg(psr_pkg::REG_STEP_LENGTH, 32'h00000000);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh7FFFFFFF, 1'b1);
		drain();
		write_reg(psr_pkg::REG_STEP_LENGTH, 32'h7FFFFFFF);
		send_sample(32'sh7FFFFFFF, 1'b0);
		send_sample(32'sh80000000, 1'b1);
	endtask

	// sum samples, then finish the same profile in max mode
	task automatic test_mode_switch();
		drain();
		write_reg(psr_pkg::REG_MODE, {29'd0, psr_pkg::MODE_SUM});
		send_sample(32'sh00050000, 1'b0);
		send_sample(32'shFFFD0000, 1'b0);
		drain();
		write_reg(psr_pkg::REG_MODE, {29'd0, psr_pkg::MODE_MAX});
		send_sample(32'sh00020000, 1'b1);
	endtask

	// samples past the limit are dropped, a dropped last still closes the profile
	task automatic test_saturation();
		drain();
		write_reg(psr_pkg::REG_MODE, {29'd0, psr_pkg::MODE_MAX});
		for (int i = 0; i < 300; i++)
			send_sample((i < MAX_SAMPLES) ? 32'(i) : 32'sh7FFFFFFF, i == 299);
		drain();
		write_reg(psr_pkg::REG_MODE, {29'd0, psr_pkg::MODE_AVG});
		for (int i = 0; i < 260; i++)
			send_sample((i % 3 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF, i == 259);
	endtask

	task automatic randomize_config();
		int   m;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] r;
		m = $urandom_range(0, 13);
		write_reg(psr_pkg::REG_MODE, (m < 12) ? 32'(m % 6) : 32'(m - 6));
		r = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				lo = -32'($urandom_range(0, 32'h00040000));
				hi = 32'($urandom_range(0, 32'h00040000));
			end
			1: begin
				lo = $urandom;
				hi = $urandom;
			end
			2: begin
				lo = 32'h80000000;
				hi = 32'h7FFFFFFF;
			end
			default: begin
				lo = r;
				hi = r;
			end
		endcase
		write_reg(psr_pkg::REG_WINDOW_LOW, lo);
		write_reg(psr_pkg::REG_WINDOW_HIGH, hi);
		case ($urandom_range(0, 9))
			0:       write_reg(psr_pkg::REG_STEP_LENGTH, 32'h00000001);
			1:       write_reg(psr_pkg::REG_STEP_LENGTH, 32'h7FFFFFFF);
			2:       write_reg(psr_pkg::REG_STEP_LENGTH, 32'h00000000);
			3, 4:    write_reg(psr_pkg::REG_STEP_LENGTH, 32'h00010000);
			default: write_reg(psr_pkg::REG_STEP_LENGTH, $urandom & 32'h7FFFFFFF);
		endcase
		case ($urandom_range(0, 3))
			0:       write_reg(psr_pkg::REG_FIRST_WEIGHT, 32'h00000000);
			1:       write_reg(psr_pkg::REG_FIRST_WEIGHT, 32'h0000FFFF);
			default: write_reg(psr_pkg::REG_FIRST_WEIGHT, $urandom_range(0, 16'hFFFF));
		endcase
		case ($urandom_range(0, 3))
			0:       write_reg(psr_pkg::REG_WEIGHT_RATIO, 32'h00000000);
			1:       write_reg(psr_pkg::REG_WEIGHT_RATIO, 32'h0000FFFF);
			default: write_reg(psr_pkg::REG_WEIGHT_RATIO, $urandom_range(0, 16'hFFFF));
		endcase
	endtask

	task automatic test_random_profiles();
		int sent;
		int len;
		int n_prof;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			// one long stretch with both sides running flat out
			no_gaps = (sent >= 400 && sent < 700);
			randomize_config();
			n_prof = $urandom_range(1, 8);
			for (int p = 0; p < n_prof; p++) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 270)
					: $urandom_range(1, 16);
				for (int i = 0; i < len; i++)
					send_sample(pick_sample(), i == len - 1);
				sent += len;
			end
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (out_valid && !out_stall) begin
			if (profile_results_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected transaction: reduced=%h extreme_index=%0d",
						reduced, extreme_index);
				mismatches++;
			end else begin
				want = profile_results_due.pop_front();
				if (want.reduced !== reduced || want.ext_idx !== extreme_index) begin
					if (mismatches < 10)
						$display("mismatch: reduced exp %h got %h, extreme_index exp %0d got %0d",
							want.reduced, reduced, want.ext_idx, extreme_index);
					mismatches++;
				end
			end
		end
		out_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_mode();
		test_each_mode();
		test_window_corners();
		test_mode_switch();
		test_saturation();
		test_random_profiles();
		drain();
		if (mismatches == 0 && profile_results_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
src/psr_pkg.sv
src/psr_div.sv
src/profile_sample_reducer_core.sv
dv/tb_top.sv
